@@ rtl/tccs_pkg.sv @@
`default_nettype none

package tccs_pkg;

  // field widths of one transaction on each channel
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned COLOR_W = 4;
  localparam int unsigned RROW_W  = 5;
  localparam int unsigned RCOL_W  = 7;
  localparam int unsigned CELL_W  = 16;
  localparam int unsigned IDX_W   = 11;
  localparam int unsigned CROW_W  = 5;
  localparam int unsigned CCOL_W  = 7;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'd10;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [CHAR_W-1:0]  character;
    logic [COLOR_W-1:0] fore_color;
    logic [COLOR_W-1:0] back_color;
    logic               end_of_string;
    logic [RROW_W-1:0]  read_row;
    logic [RCOL_W-1:0]  read_column;
  } in_item_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_value;
    logic [IDX_W-1:0]  cell_index;
    logic              cell_written;
    logic              scrolled;
    logic [CROW_W-1:0] cursor_row;
    logic [CCOL_W-1:0] cursor_column;
  } out_item_t;

  // datapath to controller
  typedef struct packed {
    logic in_is_put;
    logic in_is_newline;
    logic in_is_read;
    logic in_is_clear;
    logic wrap_pending;
    logic col_last;
    logic last_row;
    logic sweep_last;
    logic eos;
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic clear_all;
    logic read_issue;
    logic read_latch;
    logic row_next;
    logic scroll_begin;
    logic scroll_end;
    logic sweep_step;
    logic write_cell;
    logic publish;
  } cmd_t;

endpackage

`default_nettype wire

@@ rtl/tccs_in_if.sv @@
`default_nettype none

interface tccs_in_if;
  import tccs_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [CHAR_W-1:0]  character;
  logic [COLOR_W-1:0] fore_color;
  logic [COLOR_W-1:0] back_color;
  logic               end_of_string;
  logic [RROW_W-1:0]  read_row;
  logic [RCOL_W-1:0]  read_column;

  modport source (
    output valid, kind, character, fore_color, back_color, end_of_string,
    output read_row, read_column,
    input  ready
  );

  modport sink (
    input  valid, kind, character, fore_color, back_color, end_of_string,
    input  read_row, read_column,
    output ready
  );

endinterface

`default_nettype wire

@@ rtl/tccs_out_if.sv @@
`default_nettype none

interface tccs_out_if;
  import tccs_pkg::*;

  logic              valid;
  logic              ready;
  logic [CELL_W-1:0] cell_value;
  logic [IDX_W-1:0]  cell_index;
  logic              cell_written;
  logic              scrolled;
  logic [CROW_W-1:0] cursor_row;
  logic [CCOL_W-1:0] cursor_column;

  modport source (
    output valid, cell_value, cell_index, cell_written, scrolled,
    output cursor_row, cursor_column,
    input  ready
  );

  modport sink (
    input  valid, cell_value, cell_index, cell_written, scrolled,
    input  cursor_row, cursor_column,
    output ready
  );

endinterface

`default_nettype wire

@@ rtl/tccs_ctrl.sv @@
`default_nettype none

module tccs_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  input  wire tccs_pkg::status_t status_i,
  output tccs_pkg::cmd_t        cmd_o
);
  import tccs_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_CLEAR   = 7'b0000010,
    S_ADVANCE = 7'b0000100,
    S_SCROLL  = 7'b0001000,
    S_WRITE   = 7'b0010000,
    S_READ    = 7'b0100000,
    S_FINISH  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   after_write_q, after_write_d;
  logic   pend_resp_q, pend_resp_d;
  logic   out_valid_q, out_valid_d;
  cmd_t   cmd;

  always_comb begin
    state_d       = state_q;
    after_write_d = after_write_q;
    pend_resp_d   = pend_resp_q;
    cmd           = '0;
    in_ready_o    = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd.capture = 1'b1;
          if (status_i.in_is_clear) begin
            cmd.clear_all = 1'b1;
            pend_resp_d   = 1'b1;
            state_d       = S_CLEAR;
          end else if (status_i.in_is_read) begin
            cmd.read_issue = 1'b1;
            state_d        = S_READ;
          end else if (status_i.in_is_newline) begin
            after_write_d = 1'b0;
            state_d       = S_ADVANCE;
          end else if (status_i.in_is_put) begin
            if (status_i.wrap_pending) begin
              after_write_d = 1'b1;
              state_d       = S_ADVANCE;
            end else begin
              state_d = S_WRITE;
            end
          end else begin
            state_d = S_FINISH;
          end
        end
      end
      S_CLEAR: begin
        cmd.sweep_step = 1'b1;
        if (status_i.sweep_last) begin
          state_d     = pend_resp_q ? S_FINISH : S_IDLE;
          pend_resp_d = 1'b0;
        end
      end
      S_ADVANCE: begin
        if (status_i.last_row) begin
          cmd.scroll_begin = 1'b1;
          state_d          = S_SCROLL;
        end else begin
          cmd.row_next = 1'b1;
          state_d      = after_write_q ? S_WRITE : S_FINISH;
        end
      end
      S_SCROLL: begin
        cmd.sweep_step = 1'b1;
        if (status_i.sweep_last) begin
          cmd.scroll_end = 1'b1;
          state_d        = after_write_q ? S_WRITE : S_FINISH;
        end
      end
      S_WRITE: begin
        cmd.write_cell = 1'b1;
        if (status_i.eos && status_i.col_last) begin
          after_write_d = 1'b0;
          state_d       = S_ADVANCE;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_READ: begin
        cmd.read_latch = 1'b1;
        state_d        = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd.publish = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.publish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLEAR;
      after_write_q <= 1'b0;
      pend_resp_q   <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      after_write_q <= after_write_d;
      pend_resp_q   <= pend_resp_d;
      out_valid_q   <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

`ifndef SYNTHESIS
  a_publish_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.publish |-> (!out_valid_q || out_ready_i))
    else $error("result published over an untaken result");

  a_publish_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.publish |=> out_valid_o)
    else $error("published result not shown");

  a_one_item_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second transaction taken while one is in flight");
`endif

endmodule

`default_nettype wire

@@ rtl/tccs_dp.sv @@
`default_nettype none

module tccs_dp #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire tccs_pkg::in_item_t  in_item_i,
  input  wire tccs_pkg::cmd_t      cmd_i,
  output tccs_pkg::status_t        status_o,
  output tccs_pkg::out_item_t      out_item_o
);
  import tccs_pkg::*;

  localparam int unsigned CELLS = ROWS * COLUMNS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned RW    = $clog2(ROWS);
  localparam int unsigned RW1   = RW + 1;
  localparam int unsigned CW    = $clog2(COLUMNS + 1);

  // cursor, ring top and sweep pointer
  logic [RW-1:0] top_q, top_d;
  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] col_q, col_d;
  logic [AW-1:0] sweep_addr_q, sweep_addr_d;
  logic [AW-1:0] sweep_end_q, sweep_end_d;

  // working item and result
  logic [CELL_W-1:0] cell_q;
  logic              eos_q;
  logic              in_range_q;
  logic [CELL_W-1:0] res_value_q;
  logic [AW-1:0]     res_index_q;
  logic              res_written_q;
  logic              res_scrolled_q;
  logic [CELL_W-1:0] rdata_q;
  out_item_t         out_q;

  logic [CELL_W-1:0] cells_q [CELLS];

  logic [RW-1:0]     row_sel;
  logic [CW-1:0]     col_sel;
  logic [RW1-1:0]    prow_sum;
  logic [RW-1:0]     prow;
  logic [AW-1:0]     phys_addr;
  logic [AW-1:0]     log_idx;
  logic [AW-1:0]     top_base;
  logic              in_range;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CELL_W-1:0] mem_wdata;

  // address unit, shared by the read item and the cursor write
  assign row_sel  = cmd_i.capture ? RW'(in_item_i.read_row) : row_q;
  assign col_sel  = cmd_i.capture ? CW'(in_item_i.read_column) : col_q;
  assign prow_sum = RW1'(top_q) + RW1'(row_sel);
  assign prow     = (prow_sum >= RW1'(ROWS)) ? RW'(prow_sum - RW1'(ROWS)) : RW'(prow_sum);
  assign phys_addr = AW'(prow) * AW'(COLUMNS) + AW'(col_sel);
  assign log_idx   = AW'(row_sel) * AW'(COLUMNS) + AW'(col_sel);
  assign top_base  = AW'(top_q) * AW'(COLUMNS);

  assign in_range = (32'(in_item_i.read_row) < ROWS) && (32'(in_item_i.read_column) < COLUMNS);

  assign status_o.in_is_put     = (in_item_i.kind == KIND_PUT);
  assign status_o.in_is_newline = (in_item_i.kind == KIND_PUT) &&
                                  (in_item_i.character == NEWLINE_CHAR);
  assign status_o.in_is_read    = (in_item_i.kind == KIND_READ);
  assign status_o.in_is_clear   = (in_item_i.kind == KIND_CLEAR);
  assign status_o.wrap_pending  = (col_q == CW'(COLUMNS));
  assign status_o.col_last      = (col_q == CW'(COLUMNS - 1));
  assign status_o.last_row      = (row_q == RW'(ROWS - 1));
  assign status_o.sweep_last    = (sweep_addr_q == sweep_end_q);
  assign status_o.eos           = eos_q;

  always_comb begin
    top_d        = top_q;
    row_d        = row_q;
    col_d        = col_q;
    sweep_addr_d = sweep_addr_q;
    sweep_end_d  = sweep_end_q;
    if (cmd_i.clear_all) begin
      top_d        = '0;
      row_d        = '0;
      col_d        = '0;
      sweep_addr_d = '0;
      sweep_end_d  = AW'(CELLS - 1);
    end
    if (cmd_i.scroll_begin) begin
      sweep_addr_d = top_base;
      sweep_end_d  = top_base + AW'(COLUMNS - 1);
    end
    if (cmd_i.sweep_step) begin
      sweep_addr_d = sweep_addr_q + AW'(1);
    end
    if (cmd_i.row_next) begin
      row_d = row_q + RW'(1);
      col_d = '0;
    end
    if (cmd_i.scroll_end) begin
      top_d = (top_q == RW'(ROWS - 1)) ? '0 : top_q + RW'(1);
      row_d = RW'(ROWS - 1);
      col_d = '0;
    end
    if (cmd_i.write_cell) begin
      col_d = col_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q        <= '0;
      row_q        <= '0;
      col_q        <= '0;
      sweep_addr_q <= '0;
      sweep_end_q  <= AW'(CELLS - 1);
    end else begin
      top_q        <= top_d;
      row_q        <= row_d;
      col_q        <= col_d;
      sweep_addr_q <= sweep_addr_d;
      sweep_end_q  <= sweep_end_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cell_q         <= {in_item_i.back_color, in_item_i.fore_color, in_item_i.character};
      eos_q          <= in_item_i.end_of_string;
      in_range_q     <= in_range;
      res_value_q    <= '0;
      res_index_q    <= (in_item_i.kind == KIND_READ && in_range) ? log_idx : '0;
      res_written_q  <= 1'b0;
      res_scrolled_q <= 1'b0;
    end
    if (cmd_i.scroll_end) begin
      res_scrolled_q <= 1'b1;
    end
    if (cmd_i.write_cell) begin
      res_value_q   <= cell_q;
      res_index_q   <= log_idx;
      res_written_q <= 1'b1;
    end
    if (cmd_i.read_latch) begin
      res_value_q <= in_range_q ? rdata_q : '0;
    end
    if (cmd_i.publish) begin
      out_q.cell_value    <= res_value_q;
      out_q.cell_index    <= IDX_W'(res_index_q);
      out_q.cell_written  <= res_written_q;
      out_q.scrolled      <= res_scrolled_q;
      out_q.cursor_row    <= CROW_W'(row_q);
      out_q.cursor_column <= CCOL_W'(col_q);
    end
  end

  // single write port: clearing sweep or cursor write
  assign mem_we    = cmd_i.sweep_step || cmd_i.write_cell;
  assign mem_waddr = cmd_i.sweep_step ? sweep_addr_q : phys_addr;
  assign mem_wdata = cmd_i.sweep_step ? '0 : cell_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cells_q[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.read_issue) begin
      rdata_q <= cells_q[phys_addr];
    end
  end

  assign out_item_o = out_q;

`ifndef SYNTHESIS
  a_no_port_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.sweep_step && cmd_i.write_cell))
    else $error("sweep and cell write in the same cycle");

  a_write_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.write_cell |-> (32'(col_q) < COLUMNS))
    else $error("cell write with a wrap pending");

  a_cursor_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(col_q) <= COLUMNS) && (32'(row_q) < ROWS) && (32'(top_q) < ROWS))
    else $error("cursor or top row out of range");
`endif

endmodule

`default_nettype wire

@@ rtl/text_console_cursor_scroll_top.sv @@
`default_nettype none

// Text console engine: a ROWS x COLUMNS grid of 16-bit cells (character in
// bits 7..0, foreground in 11..8, background in 15..12) kept as a ring of rows
// in one on-chip memory, plus a cursor. Each input transaction (a put, a read,
// a clear or any other kind) gives exactly one output transaction with the
// affected cell, its logical index and the cursor afterwards. One item is
// handled at a time; the input side is taken again as soon as the result sits
// in the output register, so a waiting result does not hold off the next item.
// A wrap (pending before the character or taken at the end of a string) runs
// an extra advance step, and a scroll zeroes the new bottom row one cell per
// cycle through the single memory write port; a clear zeroes every cell the
// same way. After reset the block runs a clearing pass over the memory before
// it takes its first item.

module text_console_cursor_scroll_top #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tccs_in_if.sink   in_i,
  tccs_out_if.source out_o
);
  import tccs_pkg::*;

  in_item_t  in_item;
  out_item_t out_item;
  status_t   status;
  cmd_t      cmd;
  logic      in_ready;
  logic      out_valid;

  // input payload gathered for the datapath
  assign in_item.kind          = in_i.kind;
  assign in_item.character     = in_i.character;
  assign in_item.fore_color    = in_i.fore_color;
  assign in_item.back_color    = in_i.back_color;
  assign in_item.end_of_string = in_i.end_of_string;
  assign in_item.read_row      = in_i.read_row;
  assign in_item.read_column   = in_i.read_column;

  assign in_i.ready = in_ready;

  // sequencer: decodes the item, runs wraps, scrolls and clearing sweeps
  tccs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // cell memory, cursor, ring pointer and the output register
  tccs_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_item_o (out_item)
  );

  // output transaction
  assign out_o.valid         = out_valid;
  assign out_o.cell_value    = out_item.cell_value;
  assign out_o.cell_index    = out_item.cell_index;
  assign out_o.cell_written  = out_item.cell_written;
  assign out_o.scrolled      = out_item.scrolled;
  assign out_o.cursor_row    = out_item.cursor_row;
  assign out_o.cursor_column = out_item.cursor_column;

endmodule

`default_nettype wire

@@ tb/sv/text_console_cursor_scroll_checker.sv @@
`timescale 1ns / 100ps

// watches both channels, keeps its own copy of the console and compares
// every output transaction with the oldest predicted one
module text_console_cursor_scroll_checker #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tccs_in_if         in_mon_i,
  tccs_out_if        out_mon_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned scroll_count_o,
  output int unsigned wrap_count_o,
  output int unsigned read_hit_count_o
);
  import tccs_pkg::*;

  logic [CELL_W-1:0] screen_cells [ROWS*COLUMNS];
  int unsigned ring_top;
  int unsigned cur_row;
  int unsigned cur_col;

  out_item_t   expected_cells[$];
  int unsigned mismatch_total;
  int unsigned waiting;
  int unsigned scroll_total;
  int unsigned wrap_total;
  int unsigned read_hits;

  assign fail_count_o     = mismatch_total;
  assign pending_o        = waiting;
  assign scroll_count_o   = scroll_total;
  assign wrap_count_o     = wrap_total;
  assign read_hit_count_o = read_hits;

  function automatic void clear_console();
    foreach (screen_cells[i]) screen_cells[i] = '0;
    ring_top = 0;
    cur_row  = 0;
    cur_col  = 0;
  endfunction

  // physical slot of a logical cell in the ring of rows
  function automatic int unsigned ring_slot(input int unsigned row, input int unsigned col);
    return ((ring_top + row) % ROWS) * COLUMNS + col;
  endfunction

  // column 0 of the next row, scrolling at the bottom; 1 if it scrolled
  function automatic bit advance_row();
    cur_col = 0;
    if (cur_row + 1 < ROWS) begin
      cur_row++;
      return 1'b0;
    end
    for (int unsigned c = 0; c < COLUMNS; c++) screen_cells[ring_top*COLUMNS + c] = '0;
    ring_top = (ring_top + 1) % ROWS;
    cur_row  = ROWS - 1;
    return 1'b1;
  endfunction

  function automatic out_item_t predict_console(input in_item_t it);
    out_item_t res;
    bit        rolled;
    res    = '0;
    rolled = 1'b0;
    case (it.kind)
      KIND_PUT: begin
        if (it.character == NEWLINE_CHAR) begin
          rolled = advance_row();
        end else begin
          // a pending wrap is taken before the cell is written
          if (cur_col >= COLUMNS) rolled = advance_row();
          res.cell_value   = {it.back_color, it.fore_color, it.character};
          res.cell_index   = IDX_W'(cur_row * COLUMNS + cur_col);
          res.cell_written = 1'b1;
          screen_cells[ring_slot(cur_row, cur_col)] = res.cell_value;
          cur_col++;
          if (it.end_of_string && cur_col >= COLUMNS) begin
            if (advance_row()) rolled = 1'b1;
          end
        end
      end
      KIND_READ: begin
        if (it.read_row < ROWS && it.read_column < COLUMNS) begin
          res.cell_value = screen_cells[ring_slot(it.read_row, it.read_column)];
          res.cell_index = IDX_W'(it.read_row * COLUMNS + it.read_column);
        end
      end
      KIND_CLEAR: clear_console();
      default: ;
    endcase
    res.scrolled      = rolled;
    res.cursor_row    = CROW_W'(cur_row);
    res.cursor_column = CCOL_W'(cur_col);
    return res;
  endfunction

  function automatic bit field_ok(input string name, input logic [31:0] want,
                                  input logic [31:0] got);
    if (got === want) return 1'b1;
    $error("%s mismatch: expected %0d, actual %0d", name, want, got);
    return 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : observe
    in_item_t  taken;
    out_item_t got;
    out_item_t want;
    bit        ok;
    if (!rst_ni) begin
      clear_console();
      expected_cells.delete();
      mismatch_total = 0;
      waiting        = 0;
      scroll_total   = 0;
      wrap_total     = 0;
      read_hits      = 0;
    end else begin
      if (out_mon_i.valid && out_mon_i.ready) begin
        got.cell_value    = out_mon_i.cell_value;
        got.cell_index    = out_mon_i.cell_index;
        got.cell_written  = out_mon_i.cell_written;
        got.scrolled      = out_mon_i.scrolled;
        got.cursor_row    = out_mon_i.cursor_row;
        got.cursor_column = out_mon_i.cursor_column;
        if (expected_cells.size() == 0) begin
          $error("output transaction with nothing expected: cell_value %0d cell_index %0d",
                 got.cell_value, got.cell_index);
          mismatch_total++;
        end else begin
          want = expected_cells.pop_front();
          ok = field_ok("cell_value", 32'(want.cell_value), 32'(got.cell_value))
             & field_ok("cell_index", 32'(want.cell_index), 32'(got.cell_index))
             & field_ok("cell_written", 32'(want.cell_written), 32'(got.cell_written))
             & field_ok("scrolled", 32'(want.scrolled), 32'(got.scrolled))
             & field_ok("cursor_row", 32'(want.cursor_row), 32'(got.cursor_row))
             & field_ok("cursor_column", 32'(want.cursor_column),
                        32'(got.cursor_column));
          if (!ok) mismatch_total++;
        end
      end
      if (in_mon_i.valid && in_mon_i.ready) begin
        taken.kind          = in_mon_i.kind;
        taken.character     = in_mon_i.character;
        taken.fore_color    = in_mon_i.fore_color;
        taken.back_color    = in_mon_i.back_color;
        taken.end_of_string = in_mon_i.end_of_string;
        taken.read_row      = in_mon_i.read_row;
        taken.read_column   = in_mon_i.read_column;
        want = predict_console(taken);
        if (want.scrolled) scroll_total++;
        if (want.cursor_column == COLUMNS) wrap_total++;
        if (taken.kind == KIND_READ && taken.read_row < ROWS && taken.read_column < COLUMNS)
          read_hits++;
        expected_cells.push_back(want);
      end
      waiting = expected_cells.size();
    end
  end

endmodule

@@ tb/sv/text_console_cursor_scroll_top_tb.sv @@
`timescale 1ns / 100ps

// stimulus and verdict for the text console; all prediction and checking
// lives in the checker instantiated beside the block
module text_console_cursor_scroll_top_tb;
  import tccs_pkg::*;

  localparam int unsigned COLUMNS = 80;
  localparam int unsigned ROWS    = 25;

  // the one kind code the block must ignore
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam int unsigned RANDOM_ITEMS    = 1300;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  // long enough to catch a stray output after the last result
  localparam int unsigned DRAIN_CYCLES    = 2 * COLUMNS + 20;
  // run-time limit covering clears, scrolls, long stalls on both sides and the
  // clearing pass after reset
  localparam longint unsigned RUN_LIMIT_NS = 40_000_000;

  logic clk;
  logic rst_n;
  logic hold_off_req;

  int unsigned items_sent;
  int unsigned no_gap_left;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned scroll_count;
  int unsigned wrap_count;
  int unsigned read_hits;

  tccs_in_if  in_ch ();
  tccs_out_if out_ch ();

  text_console_cursor_scroll_top #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  text_console_cursor_scroll_checker #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) console_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_mon_i        (in_ch),
    .out_mon_i       (out_ch),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .scroll_count_o  (scroll_count),
    .wrap_count_o    (wrap_count),
    .read_hit_count_o(read_hits)
  );

  // 50 MHz
  initial begin : clock_gen
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // reset asserted once, then released
  initial begin : reset_gen
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  // hard stop in case a result never shows up
  initial begin : run_limit
    #(RUN_LIMIT_NS);
    $display("FAIL text_console_cursor_scroll_top");
    $finish;
  end

  // idle length: mostly none, often short, now and then long
  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // every field random, so unused fields still see both values on every bit
  function automatic in_item_t random_fields();
    logic [31:0] raw;
    raw = $urandom;
    return in_item_t'(raw[$bits(in_item_t)-1:0]);
  endfunction

  function automatic in_item_t put_item(input logic [CHAR_W-1:0] ch,
                                        input logic [COLOR_W-1:0] fg,
                                        input logic [COLOR_W-1:0] bg,
                                        input logic eos);
    in_item_t it;
    it               = random_fields();
    it.kind          = KIND_PUT;
    it.character     = ch;
    it.fore_color    = fg;
    it.back_color    = bg;
    it.end_of_string = eos;
    return it;
  endfunction

  function automatic in_item_t read_item(input int unsigned row, input int unsigned col);
    in_item_t it;
    it             = random_fields();
    it.kind        = KIND_READ;
    it.read_row    = RROW_W'(row);
    it.read_column = RCOL_W'(col);
    return it;
  endfunction

  function automatic in_item_t kind_item(input logic [KIND_W-1:0] k);
    in_item_t it;
    it      = random_fields();
    it.kind = k;
    return it;
  endfunction

  // any byte except the newline
  function automatic logic [CHAR_W-1:0] text_char();
    int unsigned ch;
    ch = $urandom_range(0, 254);
    if (ch >= NEWLINE_CHAR) ch++;
    return CHAR_W'(ch);
  endfunction

  function automatic in_item_t text_put(input logic eos);
    return put_item(text_char(), COLOR_W'($urandom), COLOR_W'($urandom), eos);
  endfunction

  function automatic in_item_t newline_put();
    return put_item(NEWLINE_CHAR, COLOR_W'($urandom), COLOR_W'($urandom), 1'($urandom));
  endfunction

  task automatic drive_fields(input in_item_t it);
    in_ch.kind          <= it.kind;
    in_ch.character     <= it.character;
    in_ch.fore_color    <= it.fore_color;
    in_ch.back_color    <= it.back_color;
    in_ch.end_of_string <= it.end_of_string;
    in_ch.read_row      <= it.read_row;
    in_ch.read_column   <= it.read_column;
  endtask

  // offer one transaction and hold it until the block takes it; now and then
  // a stretch of back-to-back transactions with no gaps at all
  task automatic send_item(input in_item_t it);
    int unsigned gap;
    if (no_gap_left > 0) begin
      no_gap_left--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 19) == 0) no_gap_left = $urandom_range(30, 80);
      gap = idle_gap();
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    drive_fields(it);
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // stop offering and wait until the checker has seen every result; the
  // first edge lets the checker register the last accepted transaction
  task automatic wait_results_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  // one string: lengths cluster around the row width so that pending wraps,
  // wraps taken by end of string and wraps taken by the next character all
  // show up; most strings end in a newline
  task automatic send_text_line();
    int unsigned len;
    bit          last_eos;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: len = $urandom_range(1, 20);
      5:             len = COLUMNS - 1;
      6:             len = COLUMNS;
      7:             len = COLUMNS + 1;
      8:             len = 2 * COLUMNS;
      default:       len = $urandom_range(20, 120);
    endcase
    last_eos = 1'($urandom_range(0, 1));
    for (int unsigned i = 0; i < len; i++) begin
      send_item(text_put((i == len - 1) ? last_eos : ($urandom_range(0, 19) == 0)));
    end
    if ($urandom_range(0, 9) < 7) send_item(newline_put());
  endtask

  // output side: bursts of ready with random gaps, plus one long hold-off
  // while the sender keeps going so that the block backs up into its input
  initial begin : result_sink
    int unsigned run;
    int unsigned gap;
    bit          hold_done;
    out_ch.ready <= 1'b0;
    hold_done = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_off_req && !hold_done) begin
        hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      run = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 8);
      out_ch.ready <= 1'b1;
      repeat (run) @(posedge clk);
      gap = idle_gap();
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int unsigned sel;
    int unsigned n;
    bit          paused_once;
    in_ch.valid  <= 1'b0;
    hold_off_req <= 1'b0;
    drive_fields('0);
    items_sent  = 0;
    no_gap_left = 0;
    paused_once = 1'b0;
    wait (rst_n);
    @(posedge clk);

    // directed: blank screen, extreme cells, newline, out-of-range reads,
    // the unused kind, a clear and what follows it
    send_item(read_item(0, 0));
    send_item(put_item(8'h00, 4'h0, 4'h0, 1'b0));
    send_item(put_item(8'hFF, 4'hF, 4'hF, 1'b1));
    send_item(put_item(8'hA5, 4'h5, 4'hA, 1'b0));
    send_item(put_item(NEWLINE_CHAR, 4'hF, 4'hF, 1'b0));
    send_item(read_item(0, 0));
    send_item(read_item(0, 1));
    send_item(read_item(0, 2));
    send_item(read_item(ROWS - 1, COLUMNS - 1));
    send_item(read_item(ROWS, 0));
    send_item(read_item(0, COLUMNS));
    send_item(read_item(31, 127));
    send_item(read_item(ROWS - 1, 127));
    send_item(kind_item(KIND_UNUSED));
    send_item(put_item(8'h5A, 4'hA, 4'h5, 1'b1));
    send_item(put_item(NEWLINE_CHAR, 4'h0, 4'h0, 1'b1));
    send_item(put_item(NEWLINE_CHAR, 4'h0, 4'h0, 1'b0));
    send_item(kind_item(KIND_CLEAR));
    send_item(read_item(0, 1));
    send_item(put_item(8'h41, 4'h7, 4'h1, 1'b0));
    send_item(read_item(0, 0));

    // random: strings dominate, with newline bursts to drive scrolling,
    // reads of the screen, rare clears and the odd unused kind
    hold_off_req <= 1'b1;
    n = items_sent + RANDOM_ITEMS;
    while (items_sent < n) begin
      if (!paused_once && items_sent > n - RANDOM_ITEMS / 2) begin
        paused_once = 1'b1;
        wait_results_drained();
      end
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
        send_text_line();
      end else if (sel < 60) begin
        repeat ($urandom_range(1, 30)) send_item(newline_put());
      end else if (sel < 85) begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 9) == 0) send_item(kind_item(KIND_READ));
          else send_item(read_item($urandom_range(0, ROWS - 1), $urandom_range(0, COLUMNS - 1)));
        end
      end else if (sel < 88) begin
        send_item(kind_item(KIND_UNUSED));
      end else if (sel < 89) begin
        if ($urandom_range(0, 1) == 0) wait_results_drained();
        send_item(kind_item(KIND_CLEAR));
      end else begin
        // fully random put, newline included
        send_item(put_item(CHAR_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom),
                           1'($urandom)));
      end
    end

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d transactions: %0d scrolls, %0d pending wraps, %0d in-range reads",
             items_sent, scroll_count, wrap_count, read_hits);
    if (fail_count == 0) begin
      $display("PASS text_console_cursor_scroll_top");
    end else begin
      $display("FAIL text_console_cursor_scroll_top");
    end
    $finish;
  end

endmodule

@@ text_console_cursor_scroll_top.f @@
rtl/tccs_pkg.sv
rtl/tccs_in_if.sv
rtl/tccs_out_if.sv
rtl/tccs_ctrl.sv
rtl/tccs_dp.sv
rtl/text_console_cursor_scroll_top.sv
tb/sv/text_console_cursor_scroll_checker.sv
tb/sv/text_console_cursor_scroll_top_tb.sv
